/* rtl/core/pct_pkg.sv */
package pct_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int RF_DEPTH    = 24;
  localparam int RF_AW       = 5;
  localparam int PC_W        = 7;
  localparam int ACC_W       = 56;

  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

  typedef logic [5:0] code_t;

  // Operand and destination codes. Codes below RF_DEPTH live in the scratch register file.
  localparam code_t C_TX  = 6'd0;
  localparam code_t C_TY  = 6'd1;
  localparam code_t C_TZ  = 6'd2;
  localparam code_t C_QX  = 6'd3;
  localparam code_t C_QY  = 6'd4;
  localparam code_t C_QZ  = 6'd5;
  localparam code_t C_QW  = 6'd6;
  localparam code_t C_IX  = 6'd7;
  localparam code_t C_IY  = 6'd8;
  localparam code_t C_IZ  = 6'd9;
  localparam code_t C_IW  = 6'd10;
  localparam code_t C_N0  = 6'd11;
  localparam code_t C_N1  = 6'd12;
  localparam code_t C_N2  = 6'd13;
  localparam code_t C_N3  = 6'd14;
  localparam code_t C_E00 = 6'd15;
  localparam code_t C_E01 = 6'd16;
  localparam code_t C_E02 = 6'd17;
  localparam code_t C_E10 = 6'd18;
  localparam code_t C_E11 = 6'd19;
  localparam code_t C_E12 = 6'd20;
  localparam code_t C_E20 = 6'd21;
  localparam code_t C_E21 = 6'd22;
  localparam code_t C_E22 = 6'd23;
  // Object matrix entries when read, result entries when written.
  localparam code_t C_O00 = 6'd24;
  localparam code_t C_O01 = 6'd25;
  localparam code_t C_O02 = 6'd26;
  localparam code_t C_O03 = 6'd27;
  localparam code_t C_O10 = 6'd28;
  localparam code_t C_O11 = 6'd29;
  localparam code_t C_O12 = 6'd30;
  localparam code_t C_O13 = 6'd31;
  localparam code_t C_O20 = 6'd32;
  localparam code_t C_O21 = 6'd33;
  localparam code_t C_O22 = 6'd34;
  localparam code_t C_O23 = 6'd35;
  localparam code_t C_M00 = 6'd24;
  localparam code_t C_M01 = 6'd25;
  localparam code_t C_M02 = 6'd26;
  localparam code_t C_M03 = 6'd27;
  localparam code_t C_M10 = 6'd28;
  localparam code_t C_M11 = 6'd29;
  localparam code_t C_M12 = 6'd30;
  localparam code_t C_M13 = 6'd31;
  localparam code_t C_M20 = 6'd32;
  localparam code_t C_M21 = 6'd33;
  localparam code_t C_M22 = 6'd34;
  localparam code_t C_M23 = 6'd35;
  localparam code_t C_PX  = 6'd36;
  localparam code_t C_PY  = 6'd37;
  localparam code_t C_PZ  = 6'd38;
  localparam code_t C_PW  = 6'd39;
  localparam code_t C_PTX = 6'd40;
  localparam code_t C_PTY = 6'd41;
  localparam code_t C_PTZ = 6'd42;
  localparam code_t C_ZERO = 6'd43;
  localparam code_t C_ONE  = 6'd44;

  localparam logic [1:0] K_FIRST = 2'd0;
  localparam logic [1:0] K_MID   = 2'd1;
  localparam logic [1:0] K_LAST  = 2'd2;
  localparam logic [1:0] K_ONLY  = 2'd3;

  localparam logic [PC_W-1:0] INIT_FIRST  = 7'd0;
  localparam logic [PC_W-1:0] INIT_LAST   = 7'd6;
  localparam logic [PC_W-1:0] STEP_FIRST  = 7'd7;
  localparam logic [PC_W-1:0] STEP_LAST   = 7'd53;
  localparam logic [PC_W-1:0] FINAL_FIRST = 7'd54;
  localparam logic [PC_W-1:0] FINAL_LAST  = 7'd113;

  typedef struct packed {
    code_t a;
    code_t b;
    logic  neg;
    logic  dbl;
    logic  fst;
    logic  lst;
    logic  syn;
    code_t dst;
  } uop_t;

  typedef struct packed {
    logic take;
    logic wr_store;
    logic out_zero;
    logic out_ident;
    logic fetch;
    logic adv;
    logic issue;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic oob;
    logic has_parent;
    logic busy;
  } stat_t;

  typedef logic [11:0][31:0] mat_t;
  typedef logic [6:0][31:0]  piv_t;

  function automatic uop_t mk(input code_t a, input code_t b, input logic [1:0] k,
                              input logic ng, input logic db, input code_t d,
                              input logic sy);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.neg = ng;
    u.dbl = db;
    u.fst = (k == K_FIRST) || (k == K_ONLY);
    u.lst = (k == K_LAST) || (k == K_ONLY);
    u.syn = sy;
    u.dst = d;
    return u;
  endfunction

  // Each entry adds one rounded product, possibly doubled or negated, to the accumulator.
  function automatic uop_t pct_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_TX, 1'b0);
      7'd1:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_TY, 1'b0);
      7'd2:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_TZ, 1'b0);
      7'd3:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_QX, 1'b0);
      7'd4:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_QY, 1'b0);
      7'd5:   u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_QZ, 1'b0);
      7'd6:   u = mk(C_ONE,  C_ONE, K_ONLY, 1'b0, 1'b0, C_QW, 1'b0);
      7'd7:   u = mk(C_PW, C_TX, K_FIRST, 1'b0, 1'b0, C_IX, 1'b0);
      7'd8:   u = mk(C_PY, C_TZ, K_MID,   1'b0, 1'b0, C_IX, 1'b0);
      7'd9:   u = mk(C_TY, C_PZ, K_LAST,  1'b1, 1'b0, C_IX, 1'b0);
      7'd10:  u = mk(C_PW, C_TY, K_FIRST, 1'b0, 1'b0, C_IY, 1'b0);
      7'd11:  u = mk(C_PX, C_TZ, K_MID,   1'b1, 1'b0, C_IY, 1'b0);
      7'd12:  u = mk(C_TX, C_PZ, K_LAST,  1'b0, 1'b0, C_IY, 1'b0);
      7'd13:  u = mk(C_PW, C_TZ, K_FIRST, 1'b0, 1'b0, C_IZ, 1'b0);
      7'd14:  u = mk(C_PX, C_TY, K_MID,   1'b0, 1'b0, C_IZ, 1'b0);
      7'd15:  u = mk(C_TX, C_PY, K_LAST,  1'b1, 1'b0, C_IZ, 1'b0);
      7'd16:  u = mk(C_PX, C_TX, K_FIRST, 1'b1, 1'b0, C_IW, 1'b0);
      7'd17:  u = mk(C_PY, C_TY, K_MID,   1'b1, 1'b0, C_IW, 1'b0);
      7'd18:  u = mk(C_PZ, C_TZ, K_LAST,  1'b1, 1'b0, C_IW, 1'b0);
      7'd19:  u = mk(C_IW, C_PX,  K_FIRST, 1'b1, 1'b0, C_TX, 1'b1);
      7'd20:  u = mk(C_PW, C_IX,  K_MID,   1'b0, 1'b0, C_TX, 1'b0);
      7'd21:  u = mk(C_IY, C_PZ,  K_MID,   1'b1, 1'b0, C_TX, 1'b0);
      7'd22:  u = mk(C_PY, C_IZ,  K_MID,   1'b0, 1'b0, C_TX, 1'b0);
      7'd23:  u = mk(C_PTX, C_ONE, K_LAST, 1'b0, 1'b0, C_TX, 1'b0);
      7'd24:  u = mk(C_IW, C_PY,  K_FIRST, 1'b1, 1'b0, C_TY, 1'b0);
      7'd25:  u = mk(C_PW, C_IY,  K_MID,   1'b0, 1'b0, C_TY, 1'b0);
      7'd26:  u = mk(C_IX, C_PZ,  K_MID,   1'b0, 1'b0, C_TY, 1'b0);
      7'd27:  u = mk(C_PX, C_IZ,  K_MID,   1'b1, 1'b0, C_TY, 1'b0);
      7'd28:  u = mk(C_PTY, C_ONE, K_LAST, 1'b0, 1'b0, C_TY, 1'b0);
      7'd29:  u = mk(C_IW, C_PZ,  K_FIRST, 1'b1, 1'b0, C_TZ, 1'b0);
      7'd30:  u = mk(C_PW, C_IZ,  K_MID,   1'b0, 1'b0, C_TZ, 1'b0);
      7'd31:  u = mk(C_IX, C_PY,  K_MID,   1'b1, 1'b0, C_TZ, 1'b0);
      7'd32:  u = mk(C_PX, C_IY,  K_MID,   1'b0, 1'b0, C_TZ, 1'b0);
      7'd33:  u = mk(C_PTZ, C_ONE, K_LAST, 1'b0, 1'b0, C_TZ, 1'b0);
      7'd34:  u = mk(C_PW, C_QX, K_FIRST, 1'b0, 1'b0, C_N0, 1'b0);
      7'd35:  u = mk(C_QW, C_PX, K_MID,   1'b0, 1'b0, C_N0, 1'b0);
      7'd36:  u = mk(C_PY, C_QZ, K_MID,   1'b0, 1'b0, C_N0, 1'b0);
      7'd37:  u = mk(C_QY, C_PZ, K_LAST,  1'b1, 1'b0, C_N0, 1'b0);
      7'd38:  u = mk(C_PW, C_QY, K_FIRST, 1'b0, 1'b0, C_N1, 1'b0);
      7'd39:  u = mk(C_QW, C_PY, K_MID,   1'b0, 1'b0, C_N1, 1'b0);
      7'd40:  u = mk(C_PX, C_QZ, K_MID,   1'b1, 1'b0, C_N1, 1'b0);
      7'd41:  u = mk(C_QX, C_PZ, K_LAST,  1'b0, 1'b0, C_N1, 1'b0);
      7'd42:  u = mk(C_PW, C_QZ, K_FIRST, 1'b0, 1'b0, C_N2, 1'b0);
      7'd43:  u = mk(C_QW, C_PZ, K_MID,   1'b0, 1'b0, C_N2, 1'b0);
      7'd44:  u = mk(C_PX, C_QY, K_MID,   1'b0, 1'b0, C_N2, 1'b0);
      7'd45:  u = mk(C_QX, C_PY, K_LAST,  1'b1, 1'b0, C_N2, 1'b0);
      7'd46:  u = mk(C_PW, C_QW, K_FIRST, 1'b0, 1'b0, C_N3, 1'b0);
      7'd47:  u = mk(C_PX, C_QX, K_MID,   1'b1, 1'b0, C_N3, 1'b0);
      7'd48:  u = mk(C_PY, C_QY, K_MID,   1'b1, 1'b0, C_N3, 1'b0);
      7'd49:  u = mk(C_PZ, C_QZ, K_LAST,  1'b1, 1'b0, C_N3, 1'b0);
      7'd50:  u = mk(C_N0, C_ONE, K_ONLY, 1'b0, 1'b0, C_QX, 1'b1);
      7'd51:  u = mk(C_N1, C_ONE, K_ONLY, 1'b0, 1'b0, C_QY, 1'b0);
      7'd52:  u = mk(C_N2, C_ONE, K_ONLY, 1'b0, 1'b0, C_QZ, 1'b0);
      7'd53:  u = mk(C_N3, C_ONE, K_ONLY, 1'b0, 1'b0, C_QW, 1'b0);
      7'd54:  u = mk(C_ONE, C_ONE, K_FIRST, 1'b0, 1'b0, C_E00, 1'b0);
      7'd55:  u = mk(C_QY, C_QY,   K_MID,   1'b1, 1'b1, C_E00, 1'b0);
      7'd56:  u = mk(C_QZ, C_QZ,   K_LAST,  1'b1, 1'b1, C_E00, 1'b0);
      7'd57:  u = mk(C_QX, C_QY,   K_FIRST, 1'b0, 1'b1, C_E01, 1'b0);
      7'd58:  u = mk(C_QZ, C_QW,   K_LAST,  1'b1, 1'b1, C_E01, 1'b0);
      7'd59:  u = mk(C_QX, C_QZ,   K_FIRST, 1'b0, 1'b1, C_E02, 1'b0);
      7'd60:  u = mk(C_QY, C_QW,   K_LAST,  1'b0, 1'b1, C_E02, 1'b0);
      7'd61:  u = mk(C_QX, C_QY,   K_FIRST, 1'b0, 1'b1, C_E10, 1'b0);
      7'd62:  u = mk(C_QZ, C_QW,   K_LAST,  1'b0, 1'b1, C_E10, 1'b0);
      7'd63:  u = mk(C_ONE, C_ONE, K_FIRST, 1'b0, 1'b0, C_E11, 1'b0);
      7'd64:  u = mk(C_QZ, C_QZ,   K_MID,   1'b1, 1'b1, C_E11, 1'b0);
      7'd65:  u = mk(C_QX, C_QX,   K_LAST,  1'b1, 1'b1, C_E11, 1'b0);
      7'd66:  u = mk(C_QY, C_QZ,   K_FIRST, 1'b0, 1'b1, C_E12, 1'b0);
      7'd67:  u = mk(C_QX, C_QW,   K_LAST,  1'b1, 1'b1, C_E12, 1'b0);
      7'd68:  u = mk(C_QX, C_QZ,   K_FIRST, 1'b0, 1'b1, C_E20, 1'b0);
      7'd69:  u = mk(C_QY, C_QW,   K_LAST,  1'b1, 1'b1, C_E20, 1'b0);
      7'd70:  u = mk(C_QY, C_QZ,   K_FIRST, 1'b0, 1'b1, C_E21, 1'b0);
      7'd71:  u = mk(C_QX, C_QW,   K_LAST,  1'b0, 1'b1, C_E21, 1'b0);
      7'd72:  u = mk(C_ONE, C_ONE, K_FIRST, 1'b0, 1'b0, C_E22, 1'b0);
      7'd73:  u = mk(C_QY, C_QY,   K_MID,   1'b1, 1'b1, C_E22, 1'b0);
      7'd74:  u = mk(C_QX, C_QX,   K_LAST,  1'b1, 1'b1, C_E22, 1'b0);
      7'd75:  u = mk(C_O00, C_E00, K_FIRST, 1'b0, 1'b0, C_M00, 1'b0);
      7'd76:  u = mk(C_O01, C_E10, K_MID,   1'b0, 1'b0, C_M00, 1'b0);
      7'd77:  u = mk(C_O02, C_E20, K_LAST,  1'b0, 1'b0, C_M00, 1'b0);
      7'd78:  u = mk(C_O00, C_E01, K_FIRST, 1'b0, 1'b0, C_M01, 1'b0);
      7'd79:  u = mk(C_O01, C_E11, K_MID,   1'b0, 1'b0, C_M01, 1'b0);
      7'd80:  u = mk(C_O02, C_E21, K_LAST,  1'b0, 1'b0, C_M01, 1'b0);
      7'd81:  u = mk(C_O00, C_E02, K_FIRST, 1'b0, 1'b0, C_M02, 1'b0);
      7'd82:  u = mk(C_O01, C_E12, K_MID,   1'b0, 1'b0, C_M02, 1'b0);
      7'd83:  u = mk(C_O02, C_E22, K_LAST,  1'b0, 1'b0, C_M02, 1'b0);
      7'd84:  u = mk(C_O00, C_TX,  K_FIRST, 1'b0, 1'b0, C_M03, 1'b0);
      7'd85:  u = mk(C_O01, C_TY,  K_MID,   1'b0, 1'b0, C_M03, 1'b0);
      7'd86:  u = mk(C_O02, C_TZ,  K_MID,   1'b0, 1'b0, C_M03, 1'b0);
      7'd87:  u = mk(C_O03, C_ONE, K_LAST,  1'b0, 1'b0, C_M03, 1'b0);
      7'd88:  u = mk(C_O10, C_E00, K_FIRST, 1'b0, 1'b0, C_M10, 1'b0);
      7'd89:  u = mk(C_O11, C_E10, K_MID,   1'b0, 1'b0, C_M10, 1'b0);
      7'd90:  u = mk(C_O12, C_E20, K_LAST,  1'b0, 1'b0, C_M10, 1'b0);
      7'd91:  u = mk(C_O10, C_E01, K_FIRST, 1'b0, 1'b0, C_M11, 1'b0);
      7'd92:  u = mk(C_O11, C_E11, K_MID,   1'b0, 1'b0, C_M11, 1'b0);
      7'd93:  u = mk(C_O12, C_E21, K_LAST,  1'b0, 1'b0, C_M11, 1'b0);
      7'd94:  u = mk(C_O10, C_E02, K_FIRST, 1'b0, 1'b0, C_M12, 1'b0);
      7'd95:  u = mk(C_O11, C_E12, K_MID,   1'b0, 1'b0, C_M12, 1'b0);
      7'd96:  u = mk(C_O12, C_E22, K_LAST,  1'b0, 1'b0, C_M12, 1'b0);
      7'd97:  u = mk(C_O10, C_TX,  K_FIRST, 1'b0, 1'b0, C_M13, 1'b0);
      7'd98:  u = mk(C_O11, C_TY,  K_MID,   1'b0, 1'b0, C_M13, 1'b0);
      7'd99:  u = mk(C_O12, C_TZ,  K_MID,   1'b0, 1'b0, C_M13, 1'b0);
      7'd100: u = mk(C_O13, C_ONE, K_LAST,  1'b0, 1'b0, C_M13, 1'b0);
      7'd101: u = mk(C_O20, C_E00, K_FIRST, 1'b0, 1'b0, C_M20, 1'b0);
      7'd102: u = mk(C_O21, C_E10, K_MID,   1'b0, 1'b0, C_M20, 1'b0);
      7'd103: u = mk(C_O22, C_E20, K_LAST,  1'b0, 1'b0, C_M20, 1'b0);
      7'd104: u = mk(C_O20, C_E01, K_FIRST, 1'b0, 1'b0, C_M21, 1'b0);
      7'd105: u = mk(C_O21, C_E11, K_MID,   1'b0, 1'b0, C_M21, 1'b0);
      7'd106: u = mk(C_O22, C_E21, K_LAST,  1'b0, 1'b0, C_M21, 1'b0);
      7'd107: u = mk(C_O20, C_E02, K_FIRST, 1'b0, 1'b0, C_M22, 1'b0);
      7'd108: u = mk(C_O21, C_E12, K_MID,   1'b0, 1'b0, C_M22, 1'b0);
      7'd109: u = mk(C_O22, C_E22, K_LAST,  1'b0, 1'b0, C_M22, 1'b0);
      7'd110: u = mk(C_O20, C_TX,  K_FIRST, 1'b0, 1'b0, C_M23, 1'b0);
      7'd111: u = mk(C_O21, C_TY,  K_MID,   1'b0, 1'b0, C_M23, 1'b0);
      7'd112: u = mk(C_O22, C_TZ,  K_MID,   1'b0, 1'b0, C_M23, 1'b0);
      7'd113: u = mk(C_O23, C_ONE, K_LAST,  1'b0, 1'b0, C_M23, 1'b0);
      default: u = mk(C_ZERO, C_ONE, K_ONLY, 1'b0, 1'b0, C_ZERO, 1'b0);
    endcase
    return u;
  endfunction

endpackage

/* rtl/core/pct_dp.sv */
module pct_dp import pct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            st,
  input  logic             in_opcode,
  input  logic [IDX_W-1:0] in_pivot_index,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic             in_has_parent,
  input  logic [63:0]      in_word0,
  input  logic [63:0]      in_word1,
  input  logic [63:0]      in_word2,
  input  logic [63:0]      in_word3,
  input  logic [63:0]      in_word4,
  input  logic [63:0]      in_word5,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             status,
  output mat_t             res
);

  logic [5:0][63:0]   in_w;
  logic               op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   par_in_r;
  logic               hp_in_r;
  logic [IDX_W-1:0]   cur_r;
  logic [CNT_W-1:0]   cnt_r;
  mat_t               obj_r;
  mat_t               res_r;
  logic               status_r;

  piv_t               piv_mem [STORE_DEPTH];
  logic [IDX_W-1:0]   par_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] hp_bits_r;
  piv_t               piv_r;
  piv_t               piv_wr;
  logic [IDX_W-1:0]   par_r;
  logic               phas_r;

  logic [31:0]        rf [RF_DEPTH];
  logic               s1_v_r;
  uop_t               s1_u_r;
  logic [31:0]        rfa_r;
  logic [31:0]        rfb_r;
  logic               s2_v_r;
  uop_t               s2_u_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod_nxt;
  logic signed [63:0] rnd;
  logic signed [ACC_W-1:0] term0;
  logic signed [ACC_W-1:0] term1;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [31:0]        sat_val;
  logic               wr_en;

  function automatic logic signed [31:0] pick(input code_t c, input logic [31:0] rfd,
                                              input mat_t ob, input piv_t pv);
    logic [3:0]  oi;
    logic [2:0]  pk;
    logic [31:0] v;
    oi = 4'(c - C_O00);
    pk = 3'(c - C_PX);
    if (c < C_O00) begin
      v = rfd;
    end else if (c < C_PX) begin
      v = ob[oi];
    end else if (c < C_ZERO) begin
      v = pv[pk];
    end else if (c == C_ONE) begin
      v = ONE_Q;
    end else begin
      v = '0;
    end
    return signed'(v);
  endfunction

  assign in_w = {in_word5, in_word4, in_word3, in_word2, in_word1, in_word0};

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      piv_wr[k] = obj_r[k];
    end
  end

  // Item capture and the walk pointer.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r     <= in_opcode;
      idx_r    <= in_pivot_index;
      par_in_r <= in_parent_index;
      hp_in_r  <= in_has_parent;
      cur_r    <= in_pivot_index;
      for (int r = 0; r < 3; r++) begin
        obj_r[4*r]   <= in_w[2*r][63:32];
        obj_r[4*r+1] <= in_w[2*r][31:0];
        obj_r[4*r+2] <= in_w[2*r+1][63:32];
        obj_r[4*r+3] <= in_w[2*r+1][31:0];
      end
    end else if (cmd.adv) begin
      cur_r <= par_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      hp_bits_r <= '0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_data;
      end
      if (cmd.wr_store) begin
        hp_bits_r[idx_r] <= hp_in_r;
      end
    end
  end

  // Pivot table.
  always_ff @(posedge clk) begin
    if (cmd.wr_store) begin
      piv_mem[idx_r] <= piv_wr;
      par_mem[idx_r] <= par_in_r;
    end
    if (cmd.fetch) begin
      piv_r  <= piv_mem[cur_r];
      par_r  <= par_mem[cur_r];
      phas_r <= hp_bits_r[cur_r];
    end
  end

  // Three stage multiply-accumulate: operand read, multiply, round and accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_u_r <= cmd.uop;
      rfa_r  <= rf[cmd.uop.a[RF_AW-1:0]];
      rfb_r  <= rf[cmd.uop.b[RF_AW-1:0]];
    end
    if (s1_v_r) begin
      s2_u_r <= s1_u_r;
      prod_r <= prod_nxt;
    end
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    if (wr_en && (s2_u_r.dst < code_t'(RF_DEPTH))) begin
      rf[s2_u_r.dst[RF_AW-1:0]] <= sat_val;
    end
  end

  always_comb begin
    opa      = pick(s1_u_r.a, rfa_r, obj_r, piv_r);
    opb      = pick(s1_u_r.b, rfb_r, obj_r, piv_r);
    prod_nxt = opa * opb;
  end

  always_comb begin
    rnd   = (prod_r + 64'sd32768) >>> 16;
    term0 = signed'(rnd[ACC_W-1:0]);
    term1 = s2_u_r.dbl ? (term0 <<< 1) : term0;
    term  = s2_u_r.neg ? -term1 : term1;
    acc_nxt = (s2_u_r.fst ? '0 : acc_r) + term;
    if (acc_nxt > SAT_HI) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (acc_nxt < SAT_LO) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = acc_nxt[31:0];
    end
    wr_en = s2_v_r && s2_u_r.lst;
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      res_r <= '0;
    end else if (cmd.out_ident) begin
      res_r <= {32'd0, ONE_Q, 32'd0, 32'd0, 32'd0, 32'd0,
                ONE_Q, 32'd0, 32'd0, 32'd0, 32'd0, ONE_Q};
    end else if (wr_en && (s2_u_r.dst inside {[C_M00:C_M23]})) begin
      res_r[4'(s2_u_r.dst - C_M00)] <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
    end else if (cmd.out_ident) begin
      status_r <= 1'b1;
    end else if (cmd.take || cmd.out_zero) begin
      status_r <= 1'b0;
    end
  end

  assign st.opcode     = op_r;
  assign st.oob        = {1'b0, idx_r} >= cnt_r;
  assign st.has_parent = phas_r;
  assign st.busy       = s1_v_r | s2_v_r;
  assign status        = status_r;
  assign res           = res_r;

endmodule

/* rtl/core/pct_ctrl.sv */
module pct_ctrl import pct_pkg::*; #(
  parameter int MAX_PIVOTS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output cmd_t  cmd,
  input  stat_t st
);

  localparam int SW = $clog2(MAX_PIVOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_RUN   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    SEG_INIT  = 2'd0,
    SEG_STEP  = 2'd1,
    SEG_FINAL = 2'd2
  } seg_t;

  state_t            state_r, state_nxt;
  seg_t              seg_r, seg_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic [PC_W-1:0]   seg_end;
  uop_t              uop;

  assign uop = pct_rom(pc_r);

  always_comb begin
    case (seg_r)
      SEG_INIT:  seg_end = INIT_LAST;
      SEG_STEP:  seg_end = STEP_LAST;
      SEG_FINAL: seg_end = FINAL_LAST;
      default:   seg_end = FINAL_LAST;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    pc_nxt    = pc_r;
    steps_nxt = steps_r;
    cmd       = '0;
    cmd.uop   = uop;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!st.opcode) begin
          cmd.wr_store = 1'b1;
          cmd.out_zero = 1'b1;
          state_nxt    = S_OUT;
        end else if (st.oob) begin
          cmd.out_ident = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          pc_nxt    = INIT_FIRST;
          seg_nxt   = SEG_INIT;
          steps_nxt = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // A marked entry waits until every earlier write has landed.
        if (!(uop.syn && st.busy)) begin
          cmd.issue = 1'b1;
          if (pc_r == seg_end) begin
            state_nxt = S_DRAIN;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!st.busy) begin
          case (seg_r)
            SEG_INIT: begin
              state_nxt = S_FETCH;
            end
            SEG_STEP: begin
              cmd.adv   = 1'b1;
              steps_nxt = steps_r + 1'b1;
              state_nxt = S_FETCH;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.has_parent && (steps_r != SW'(MAX_PIVOTS))) begin
          pc_nxt  = STEP_FIRST;
          seg_nxt = SEG_STEP;
        end else begin
          pc_nxt  = FINAL_FIRST;
          seg_nxt = SEG_FINAL;
        end
        state_nxt = S_RUN;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_r   <= SEG_INIT;
      pc_r    <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      pc_r    <= pc_nxt;
      steps_r <= steps_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

`ifndef SYNTHESIS
  a_sync_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && cmd.uop.syn |-> !st.busy)
    else $error("dependent entry issued while the pipeline was busy");
  a_fetch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> !st.busy)
    else $error("pivot fetched while the pipeline still used the old entry");
  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= SW'(MAX_PIVOTS))
    else $error("walk ran past its step limit");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_stall |=> (state_r == S_OUT))
    else $error("result dropped while stalled");
`endif

endmodule

/* rtl/core/pivot_chain_transform_top.sv */
// Pivot chain transform: forward kinematics over a 64 entry pivot table.
// Input channel (in_valid / in_stall): a write beat (opcode 0) loads one pivot
// entry; an evaluate beat (opcode 1) names a pivot and carries a 3x4 object matrix.
// Every input beat produces exactly one result beat on out_valid / out_stall.
// cfg_valid / cfg_ready writes pivot_count; cfg_ready is always high and the
// register should only be written while the block is idle.
// One item is handled at a time; in_stall is high from acceptance until the
// result beat has been taken.
// A write or an out of range index is decoded and goes straight to the result
// beat. An evaluate walks D parent steps (at most MAX_PIVOTS), and its time
// grows with D. It is bounded by the single shared 32x32 multiplier, which
// serves 47 products per step and 60 for the final matrix build and product;
// each step also waits twice for a dependency, and the walk adds pipeline
// drain, pivot fetch and decode.
// After reset pivot_count is zero and every entry has no parent; the rotation
// and translation contents are undefined until written.
// While the receiver stalls, the result beat holds and no new item is taken.
module pivot_chain_transform_top import pct_pkg::*; #(
  parameter int MAX_PIVOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  logic [IDX_W-1:0] in_pivot_index,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic             in_has_parent,
  input  logic [63:0]      in_word0,
  input  logic [63:0]      in_word1,
  input  logic [63:0]      in_word2,
  input  logic [63:0]      in_word3,
  input  logic [63:0]      in_word4,
  input  logic [63:0]      in_word5,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_status,
  output logic [63:0]      out_res_word0,
  output logic [63:0]      out_res_word1,
  output logic [63:0]      out_res_word2,
  output logic [63:0]      out_res_word3,
  output logic [63:0]      out_res_word4,
  output logic [63:0]      out_res_word5,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;
  mat_t  res;

  pct_ctrl #(
    .MAX_PIVOTS (MAX_PIVOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  pct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_opcode       (in_opcode),
    .in_pivot_index  (in_pivot_index),
    .in_parent_index (in_parent_index),
    .in_has_parent   (in_has_parent),
    .in_word0        (in_word0),
    .in_word1        (in_word1),
    .in_word2        (in_word2),
    .in_word3        (in_word3),
    .in_word4        (in_word4),
    .in_word5        (in_word5),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .status          (out_status),
    .res             (res)
  );

  assign cfg_ready     = 1'b1;
  assign out_res_word0 = {res[0],  res[1]};
  assign out_res_word1 = {res[2],  res[3]};
  assign out_res_word2 = {res[4],  res[5]};
  assign out_res_word3 = {res[6],  res[7]};
  assign out_res_word4 = {res[8],  res[9]};
  assign out_res_word5 = {res[10], res[11]};

endmodule
